@@ rtl/core/utf8_to_utf32_decoder_assert.svh @@
// Assertion macros for the UTF-8 to UTF-32 decoder.
`ifndef UTF8_TO_UTF32_DECODER_ASSERT_SVH
`define UTF8_TO_UTF32_DECODER_ASSERT_SVH

// Condition in a cycle implies a consequence in the same cycle.
`define U2U_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition in a cycle implies a consequence in the next cycle.
`define U2U_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/utf8dec_pkg.sv @@
// Types and constants shared by the UTF-8 decoder files.
`default_nettype none
package utf8dec_pkg;

	localparam logic [7:0] LEAD2_MASK = 8'h1F;
	localparam logic [7:0] LEAD3_MASK = 8'h0F;
	localparam logic [7:0] LEAD4_MASK = 8'h07;
	localparam logic [7:0] CONT_MASK  = 8'h3F;

	localparam int CP_BITS  = 21;
	localparam int OFF_BITS = 16;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_LEAD  = 2'd1,
		ST_TRUNCATED = 2'd2
	} status_t;

	// Pending multi-byte sequence
	typedef struct packed {
		logic [2:0]          expected_length;
		logic [2:0]          bytes_collected;
		logic [CP_BITS-1:0]  partial_point;
		logic [OFF_BITS-1:0] sequence_start;
	} seq_t;

	typedef struct packed {
		logic [CP_BITS-1:0]  code_point;
		logic [OFF_BITS-1:0] start_offset;
		status_t             status;
		logic                string_done;
	} result_t;

	localparam seq_t SEQ_IDLE = '{default: '0};

endpackage
`default_nettype wire

@@ rtl/core/utf8dec_stream_if.sv @@
// Valid/ready stream interfaces for input bytes and decoded code points.
`default_nettype none
interface utf8dec_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       final_byte;

	modport source (output valid, output code_byte, output final_byte, input ready);
	modport sink (input valid, input code_byte, input final_byte, output ready);
endinterface

interface utf8dec_cp_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic [15:0] start_offset;
	logic [1:0]  status;
	logic        string_done;

	modport source (output valid, output code_point, output start_offset,
		output status, output string_done, input ready);
	modport sink (input valid, input code_point, input start_offset,
		input status, input string_done, output ready);
endinterface
`default_nettype wire

@@ rtl/core/utf8dec_step.sv @@
// Next-state and result logic for one input word of the decoder.
`default_nettype none
module utf8dec_step #(
	parameter int OFFSET_BITS = 16
) (
	input  utf8dec_pkg::seq_t    cur,
	input  logic [OFFSET_BITS-1:0] pos,
	input  logic                 drop,
	input  logic [7:0]           code_byte,
	input  logic                 final_byte,
	output utf8dec_pkg::seq_t    nxt,
	output logic [OFFSET_BITS-1:0] nxt_pos,
	output logic                 nxt_drop,
	output utf8dec_pkg::result_t res,
	output logic                 res_valid
);
	import utf8dec_pkg::*;

	logic [OFF_BITS-1:0] pos16;
	logic [2:0]          lead_len;
	logic [CP_BITS-1:0]  lead_bits;
	logic [CP_BITS-1:0]  pp_next;
	logic [2:0]          bc_next;

	assign pos16   = OFF_BITS'(pos);
	assign pp_next = CP_BITS'({cur.partial_point, 6'(code_byte & CONT_MASK)});
	assign bc_next = cur.bytes_collected + 3'd1;

	always_comb begin
		unique casez (code_byte)
			8'b0???????: begin
				lead_len  = 3'd1;
				lead_bits = CP_BITS'(code_byte);
			end
			8'b110?????: begin
				lead_len  = 3'd2;
				lead_bits = CP_BITS'(code_byte & LEAD2_MASK);
			end
			8'b1110????: begin
				lead_len  = 3'd3;
				lead_bits = CP_BITS'(code_byte & LEAD3_MASK);
			end
			8'b11110???: begin
				lead_len  = 3'd4;
				lead_bits = CP_BITS'(code_byte & LEAD4_MASK);
			end
			default: begin
				lead_len  = 3'd0;
				lead_bits = '0;
			end
		endcase
	end

	always_comb begin
		nxt       = cur;
		nxt_drop  = drop;
		res_valid = 1'b0;
		res       = '{code_point: '0, start_offset: pos16, status: ST_OK,
			string_done: final_byte};

		if (drop) begin
			if (final_byte)
				nxt_drop = 1'b0;
		end else if (cur.expected_length == 3'd0) begin
			if (lead_len == 3'd0) begin
				res_valid  = 1'b1;
				res.status = ST_BAD_LEAD;
				if (!final_byte)
					nxt_drop = 1'b1;
			end else if (lead_len == 3'd1) begin
				res_valid      = 1'b1;
				res.code_point = lead_bits;
			end else if (final_byte) begin
				// lead byte of a multi-byte sequence ends the string
				res_valid  = 1'b1;
				res.status = ST_TRUNCATED;
			end else begin
				nxt = '{expected_length: lead_len, bytes_collected: 3'd1,
					partial_point: lead_bits, sequence_start: pos16};
			end
		end else begin
			res.start_offset = cur.sequence_start;
			if (bc_next >= cur.expected_length) begin
				res_valid      = 1'b1;
				res.code_point = pp_next;
				nxt            = SEQ_IDLE;
			end else if (final_byte) begin
				res_valid  = 1'b1;
				res.status = ST_TRUNCATED;
				nxt        = SEQ_IDLE;
			end else begin
				nxt.partial_point   = pp_next;
				nxt.bytes_collected = bc_next;
			end
		end

		if (final_byte) begin
			nxt     = SEQ_IDLE;
			nxt_pos = '0;
		end else begin
			nxt_pos = pos + 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/utf8_to_utf32_decoder.sv @@
// A byte word accepted into the input register is decoded from there, and its result
// (if any) is written into the result register, from which it is presented as valid.
// Throughput: one byte word per cycle, sustained while the result side takes words.
// The input and result registers form a two-stage pipeline that stalls as a whole.
// Reset (arst_n low, asynchronous) empties both stages, clears any pending sequence,
// the drop flag and the byte offset, so the first string starts at offset 0.
`default_nettype none
`include "utf8_to_utf32_decoder_assert.svh"
module utf8_to_utf32_decoder #(
	parameter int OFFSET_BITS = 16
) (
	input logic              clk,
	input logic              arst_n,
	utf8dec_byte_if.sink     bytes,
	utf8dec_cp_if.source     points
);
	import utf8dec_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;

	// result stage
	logic       valid_s2;
	result_t    res_s2;

	// decoder state
	seq_t                   seq_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic                   drop_q;

	seq_t                   seq_nxt;
	logic [OFFSET_BITS-1:0] pos_nxt;
	logic                   drop_nxt;
	result_t                res;
	logic                   res_valid;

	logic ready_s2;
	logic adv_s1;

	// assertion terms
	logic err_out;
	logic cp_zero;
	logic seq_busy;
	logic count_ok;
	logic fin_adv;
	logic str_clear;

	assign ready_s2    = !valid_s2 || points.ready;
	assign adv_s1      = valid_s1 && ready_s2;
	assign bytes.ready = !valid_s1 || ready_s2;

	utf8dec_step #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_step (
		.cur        (seq_q),
		.pos        (pos_q),
		.drop       (drop_q),
		.code_byte  (byte_s1),
		.final_byte (fin_s1),
		.nxt        (seq_nxt),
		.nxt_pos    (pos_nxt),
		.nxt_drop   (drop_nxt),
		.res        (res),
		.res_valid  (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			seq_q    <= SEQ_IDLE;
			pos_q    <= '0;
			drop_q   <= 1'b0;
		end else begin
			if (bytes.valid && bytes.ready)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;

			if (ready_s2)
				valid_s2 <= adv_s1 && res_valid;

			if (adv_s1) begin
				seq_q  <= seq_nxt;
				pos_q  <= pos_nxt;
				drop_q <= drop_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.code_byte;
			fin_s1  <= bytes.final_byte;
		end
		if (ready_s2)
			res_s2 <= res;
	end

	assign points.valid        = valid_s2;
	assign points.code_point   = res_s2.code_point;
	assign points.start_offset = res_s2.start_offset;
	assign points.status       = res_s2.status;
	assign points.string_done  = res_s2.string_done;

	assign err_out   = points.valid && res_s2.status != ST_OK;
	assign cp_zero   = res_s2.code_point == '0;
	assign seq_busy  = seq_q.expected_length != 3'd0;
	assign count_ok  = seq_q.bytes_collected != 3'd0 &&
		seq_q.bytes_collected < seq_q.expected_length;
	assign fin_adv   = adv_s1 && fin_s1;
	assign str_clear = pos_q == '0 && !drop_q && !seq_busy;

	`U2U_ASSERT_IMPLY(a_err_zero_cp, clk, arst_n, err_out, cp_zero, "error word has a code point")
	`U2U_ASSERT_IMPLY(a_drop_no_seq, clk, arst_n, drop_q, !seq_busy, "sequence open while dropping")
	`U2U_ASSERT_IMPLY(a_seq_count, clk, arst_n, seq_busy, count_ok, "pending count out of range")
	`U2U_ASSERT_NEXT(a_final_clears, clk, arst_n, fin_adv, str_clear, "final byte left string state")

endmodule
`default_nettype wire
